// ----- rtl/uer_pkg.sv -----
// Shared constants, types and helpers for the dual ultrasonic echo ranger.
// No dependencies; used by uer_track, uer_scale and the top level.
package uer_pkg;

  localparam int STAMP_W     = 32;
  localparam int CAP_W       = 16;
  localparam int TIMEOUT_W   = 20;
  localparam int PULSE_W     = 8;
  localparam int SPEED_W     = 10;
  localparam int DIST_W      = 19;
  localparam int DIST_SHIFT  = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED   = CFG_INDEX_W'(2);

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);
  localparam logic [PULSE_W-1:0]   PULSE_RESET   = PULSE_W'(10);
  localparam logic [SPEED_W-1:0]   SPEED_RESET   = SPEED_W'(281);

  localparam longint unsigned CAP_MAX  = (64'd1 << CAP_W) - 64'd1;
  localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 64'd1;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic             busy;
    logic             trig_left;
    logic             trig_right;
    logic [CAP_W-1:0] width;
  } track_res_t;

  // Zero for a non-positive difference, else the difference capped.
  function automatic logic [CAP_W-1:0] cap_width(input stamp_t d);
    logic [63:0] dx;
    dx = 64'(d);
    if (d == '0 || d[STAMP_W-1]) begin
      cap_width = '0;
    end else if (dx > CAP_MAX) begin
      cap_width = CAP_W'(CAP_MAX);
    end else begin
      cap_width = CAP_W'(dx);
    end
  endfunction

endpackage

// ----- rtl/dual_ultrasonic_echo_ranger.sv -----
// Top level of the dual ultrasonic echo ranger: config registers, handshake.
// Instantiates uer_track and uer_scale; depends on uer_pkg.
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+----------------------------------
//  in         | sink      | in_valid / in_stall   | start_measure side_left echo_*
//  out        | source    | out_valid / out_stall | busy_res trig_*_level distance_q8
//  cfg        | sink      | cfg_write             | cfg_index cfg_data
//
// One item per cycle unless in_stall is high; each result reaches the outputs
// through the state-update register, then the scaling register.
// The state register can hold one item while the output register is stalled.
// Reset clears time base, stamps, flags and config to defaults; no clearing pass.
module dual_ultrasonic_echo_ranger (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              start_measure,
  input  logic                              side_left,
  input  logic                              echo_left,
  input  logic                              echo_right,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              busy_res,
  output logic                              trig_left_level,
  output logic                              trig_right_level,
  output logic [uer_pkg::DIST_W-1:0]        distance_q8,
  input  logic                              cfg_write,
  input  logic [uer_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [uer_pkg::TIMEOUT_W-1:0] timeout_us;
  logic [uer_pkg::PULSE_W-1:0]   pulse_us;
  logic [uer_pkg::SPEED_W-1:0]   speed_factor;

  logic s1_valid;
  logic out_free;
  logic s1_move;
  logic in_acc;
  uer_pkg::track_res_t s1_res;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= uer_pkg::TIMEOUT_RESET;
      pulse_us <= uer_pkg::PULSE_RESET;
      speed_factor <= uer_pkg::SPEED_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        uer_pkg::CFG_TIMEOUT: timeout_us <= uer_pkg::TIMEOUT_W'(cfg_data);
        uer_pkg::CFG_PULSE:   pulse_us <= uer_pkg::PULSE_W'(cfg_data);
        uer_pkg::CFG_SPEED:   speed_factor <= uer_pkg::SPEED_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  uer_track u_track (
    .clk           (clk),
    .rst           (rst),
    .adv           (in_acc),
    .start_measure (start_measure),
    .side_left     (side_left),
    .echo_left     (echo_left),
    .echo_right    (echo_right),
    .timeout_us    (timeout_us),
    .pulse_us      (pulse_us),
    .res           (s1_res)
  );

  uer_scale u_scale (
    .clk              (clk),
    .load             (s1_move),
    .speed_factor     (speed_factor),
    .res_in           (s1_res),
    .busy_res         (busy_res),
    .trig_left_level  (trig_left_level),
    .trig_right_level (trig_right_level),
    .distance_q8      (distance_q8)
  );

`ifndef NO_ASSERTIONS
  a_trig_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trig_left_level && trig_right_level))
    else $error("both trigger pins driven high");

  a_busy_no_distance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && busy_res) |-> (distance_q8 == '0))
    else $error("distance reported while measurement pending");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- rtl/uer_track.sv -----
// Per-tick state update: time base, trigger pulse, echo edge stamps, timeout.
// Registers busy, trigger levels and capped echo width. Depends on uer_pkg.
module uer_track (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           start_measure,
  input  logic                           side_left,
  input  logic                           echo_left,
  input  logic                           echo_right,
  input  logic [uer_pkg::TIMEOUT_W-1:0]  timeout_us,
  input  logic [uer_pkg::PULSE_W-1:0]    pulse_us,
  output uer_pkg::track_res_t            res
);

  uer_pkg::stamp_t time_now, time_now_next;
  uer_pkg::stamp_t trigger_stamp, trigger_stamp_next;
  uer_pkg::stamp_t start_stamp [2];
  uer_pkg::stamp_t start_stamp_next [2];
  uer_pkg::stamp_t end_stamp [2];
  uer_pkg::stamp_t end_stamp_next [2];
  logic [1:0] done, done_next;
  logic [1:0] echo_prev, echo_prev_next;
  logic sel_left, sel_left_next;
  logic [uer_pkg::PULSE_W-1:0] pulse_cnt, pulse_cnt_next;
  uer_pkg::track_res_t res_next;

  logic [1:0] level;
  logic side_idx;
  logic sel_idx;
  logic timed_out;
  logic trig;
  uer_pkg::stamp_t elapsed;

  always_comb begin
    level = {echo_right, echo_left};
    time_now_next = time_now + uer_pkg::STAMP_W'(1);
    trigger_stamp_next = trigger_stamp;
    start_stamp_next = start_stamp;
    end_stamp_next = end_stamp;
    done_next = done;
    sel_left_next = sel_left;
    pulse_cnt_next = pulse_cnt;
    side_idx = ~side_left;

    if (start_measure) begin
      sel_left_next = side_left;
      trigger_stamp_next = time_now;
      done_next[side_idx] = 1'b0;
      start_stamp_next[side_idx] = time_now;
      end_stamp_next[side_idx] = time_now;
      pulse_cnt_next = pulse_us;
    end

    for (int s = 0; s < 2; s++) begin
      if (level[s] && !echo_prev[s]) begin
        start_stamp_next[s] = time_now;
      end
      if (!level[s] && echo_prev[s]) begin
        end_stamp_next[s] = time_now;
        done_next[s] = 1'b1;
      end
    end
    echo_prev_next = level;

    sel_idx = ~sel_left_next;
    elapsed = time_now - trigger_stamp_next;
    timed_out = !done_next[sel_idx] && (64'(elapsed) > 64'(timeout_us));
    if (timed_out) begin
      done_next[sel_idx] = 1'b1;
      end_stamp_next[sel_idx] = start_stamp_next[sel_idx];
    end

    trig = (pulse_cnt_next != '0);
    if (trig) begin
      pulse_cnt_next = pulse_cnt_next - uer_pkg::PULSE_W'(1);
    end

    res_next.busy = !done_next[sel_idx];
    res_next.trig_left = trig && sel_left_next;
    res_next.trig_right = trig && !sel_left_next;
    res_next.width = timed_out ? '0 :
        uer_pkg::cap_width(end_stamp_next[sel_idx] - start_stamp_next[sel_idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      trigger_stamp <= '0;
      start_stamp[0] <= '0;
      start_stamp[1] <= '0;
      end_stamp[0] <= '0;
      end_stamp[1] <= '0;
      done <= 2'b11;
      echo_prev <= 2'b00;
      sel_left <= 1'b1;
      pulse_cnt <= '0;
    end else if (adv) begin
      time_now <= time_now_next;
      trigger_stamp <= trigger_stamp_next;
      start_stamp <= start_stamp_next;
      end_stamp <= end_stamp_next;
      done <= done_next;
      echo_prev <= echo_prev_next;
      sel_left <= sel_left_next;
      pulse_cnt <= pulse_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/uer_scale.sv -----
// Distance scaling: width times speed factor, shifted and saturated.
// Holds the result register. Depends on uer_pkg.
module uer_scale (
  input  logic                          clk,
  input  logic                          load,
  input  logic [uer_pkg::SPEED_W-1:0]   speed_factor,
  input  uer_pkg::track_res_t           res_in,
  output logic                          busy_res,
  output logic                          trig_left_level,
  output logic                          trig_right_level,
  output logic [uer_pkg::DIST_W-1:0]    distance_q8
);

  localparam int PROD_W = uer_pkg::CAP_W + uer_pkg::SPEED_W;
  localparam int FULL_W = PROD_W - uer_pkg::DIST_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] scaled;
  logic [63:0] scaled_x;
  logic [uer_pkg::DIST_W-1:0] dist_sat;

  always_comb begin
    prod = PROD_W'(res_in.width) * PROD_W'(speed_factor);
    scaled = prod[PROD_W-1:uer_pkg::DIST_SHIFT];
    scaled_x = 64'(scaled);
    if (scaled_x > uer_pkg::DIST_MAX) begin
      dist_sat = uer_pkg::DIST_W'(uer_pkg::DIST_MAX);
    end else begin
      dist_sat = uer_pkg::DIST_W'(scaled_x);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      busy_res <= res_in.busy;
      trig_left_level <= res_in.trig_left;
      trig_right_level <= res_in.trig_right;
      distance_q8 <= dist_sat;
    end
  end

endmodule
